>>> rtl/core/urldec_pkg.sv
// Types, constants and helpers shared by the URL percent decoder.
`timescale 1ns / 1ps
package urldec_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int FIELD_COUNT_WIDTH   = 16;
   localparam int LIMIT_WIDTH         = 16;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   localparam logic [1:0] STATUS_DECODING = 2'd0;
   localparam logic [1:0] STATUS_DONE     = 2'd1;
   localparam logic [1:0] STATUS_ERROR    = 2'd2;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC1   = 2'd1,
      MODE_ESC2   = 2'd2,
      MODE_QUOTE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      HALT_NONE  = 2'd0,
      HALT_STOP  = 2'd1,
      HALT_ERROR = 2'd2
   } halt_type;

   typedef struct packed {
      logic                         out_valid;
      logic [7:0]                   out_byte;
      logic [1:0]                   status;
      logic [FIELD_COUNT_WIDTH-1:0] consumed_count;
      logic [FIELD_COUNT_WIDTH-1:0] produced_count;
   } result_type;

   // {ok, value}
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end
      return r;
   endfunction

endpackage

>>> rtl/core/urldec_core.sv
// Per-string decoder state and combinational token decode step.
`timescale 1ns / 1ps
module urldec_core #(
   parameter int COUNT_WIDTH = urldec_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_en,
   input  logic [7:0]                          in_byte,
   input  logic                                is_last,
   input  logic [urldec_pkg::LIMIT_WIDTH-1:0]  out_limit,
   output urldec_pkg::result_type              result
);
   import urldec_pkg::*;

   mode_type               mode_ff, mode_in;
   logic [3:0]             nibble_ff, nibble_in;
   logic [COUNT_WIDTH-1:0] committed_ff, committed_in;
   logic [COUNT_WIDTH-1:0] produced_ff, produced_in;
   halt_type               halt_ff, halt_in;

   mode_type               m;
   halt_type               h;
   logic [3:0]             nib;
   logic [1:0]             add_n;
   logic                   emit;
   logic [7:0]             emit_b;
   logic                   fresh;
   logic [3:0]             hv;
   logic                   hex_ok;
   logic [7:0]             esc_byte;
   logic [COUNT_WIDTH:0]   csum;
   logic [COUNT_WIDTH-1:0] com_n;
   logic [COUNT_WIDTH-1:0] out_n;
   logic [31:0]            com_w;
   logic [31:0]            out_w;
   logic [1:0]             status;

   always_comb begin
      m        = mode_ff;
      h        = halt_ff;
      nib      = nibble_ff;
      add_n    = 2'd0;
      emit     = 1'b0;
      emit_b   = 8'd0;
      fresh    = 1'b0;
      {hex_ok, hv} = hex_value(in_byte);
      esc_byte = {nibble_ff, hv};

      if (halt_ff == HALT_NONE) begin
         unique case (mode_ff)
            MODE_ESC1: begin
               if (is_last) begin
                  h = HALT_STOP;
               end else if (hex_ok) begin
                  nib = hv;
                  m   = MODE_ESC2;
               end else begin
                  h = HALT_ERROR;
               end
            end
            MODE_ESC2: begin
               if (hex_ok) begin
                  if (esc_byte != CHAR_DQUOTE && esc_byte != CHAR_SQUOTE) begin
                     emit   = 1'b1;
                     emit_b = esc_byte;
                  end
                  add_n = 2'd3;
                  m     = MODE_NORMAL;
               end else begin
                  h = HALT_ERROR;
               end
            end
            MODE_QUOTE: begin
               m = MODE_NORMAL;
               if (in_byte == CHAR_DQUOTE) begin
                  emit   = 1'b1;
                  emit_b = CHAR_DQUOTE;
                  add_n  = 2'd2;
               end else begin
                  add_n = 2'd1;
                  fresh = 1'b1;
               end
            end
            default: begin
               fresh = 1'b1;
            end
         endcase

         if (fresh) begin
            if (32'(produced_ff) >= 32'(out_limit)) begin
               h = HALT_STOP;
            end else begin
               priority if (in_byte == CHAR_PLUS) begin
                  emit   = 1'b1;
                  emit_b = CHAR_SPACE;
                  add_n  = add_n + 2'd1;
               end else if (in_byte == CHAR_PERCENT) begin
                  if (is_last) begin
                     h = HALT_STOP;
                  end else begin
                     m = MODE_ESC1;
                  end
               end else if (in_byte == CHAR_DQUOTE) begin
                  if (is_last) begin
                     add_n = add_n + 2'd1;
                  end else begin
                     m = MODE_QUOTE;
                  end
               end else if (!in_byte[7]) begin
                  emit   = 1'b1;
                  emit_b = in_byte;
                  add_n  = add_n + 2'd1;
               end else begin
                  h = HALT_ERROR;
               end
            end
         end
      end

      out_n = produced_ff;
      if (emit && produced_ff != {COUNT_WIDTH{1'b1}}) begin
         out_n = produced_ff + 1'b1;
      end
      csum  = {1'b0, committed_ff} + (COUNT_WIDTH+1)'(add_n);
      com_n = csum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : csum[COUNT_WIDTH-1:0];

      if (h == HALT_NONE && add_n != 2'd0 && 32'(out_n) >= 32'(out_limit)) begin
         h = HALT_STOP;
      end

      if (h == HALT_NONE) begin
         status = is_last ? STATUS_DONE : STATUS_DECODING;
      end else if (h == HALT_STOP) begin
         status = STATUS_DONE;
      end else begin
         status = STATUS_ERROR;
      end

      com_w = 32'(com_n);
      out_w = 32'(out_n);
      result.out_valid      = emit;
      result.out_byte       = emit_b;
      result.status         = status;
      result.consumed_count = com_w[FIELD_COUNT_WIDTH-1:0];
      result.produced_count = out_w[FIELD_COUNT_WIDTH-1:0];

      mode_in      = mode_ff;
      nibble_in    = nibble_ff;
      committed_in = committed_ff;
      produced_in  = produced_ff;
      halt_in      = halt_ff;
      if (step_en) begin
         if (is_last) begin
            mode_in      = MODE_NORMAL;
            nibble_in    = 4'd0;
            committed_in = '0;
            produced_in  = '0;
            halt_in      = HALT_NONE;
         end else begin
            mode_in      = m;
            nibble_in    = nib;
            committed_in = com_n;
            produced_in  = out_n;
            halt_in      = h;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         nibble_ff    <= 4'd0;
         committed_ff <= '0;
         produced_ff  <= '0;
         halt_ff      <= HALT_NONE;
      end else begin
         mode_ff      <= mode_in;
         nibble_ff    <= nibble_in;
         committed_ff <= committed_in;
         produced_ff  <= produced_in;
         halt_ff      <= halt_in;
      end
   end

endmodule

>>> rtl/core/url_percent_decoder_unit.sv
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the decode step and the result
// register set the rate, and a stalled result blocks new requests.
// Reset clears the decoder state and the result valid flag and sets
// the output limit to 65535.
`timescale 1ns / 1ps
module url_percent_decoder_unit #(
   parameter int COUNT_WIDTH = urldec_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,    // [7:0] in_byte
   input  logic                               req_tlast,    // is_last
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] out_byte, [9:8] status, [25:10] consumed_count,
   // [41:26] produced_count, [47:42] zero
   output logic [47:0]                        rsp_tdata,
   output logic                               rsp_tuser,    // out_valid
   input  logic                               csr_wr_en,
   input  logic [urldec_pkg::LIMIT_WIDTH-1:0] csr_wr_data   // out_limit
);
   import urldec_pkg::*;

   logic [LIMIT_WIDTH-1:0] out_limit_ff, out_limit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff, rsp_data_in;
   result_type             step_result;
   logic                   req_fire;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   urldec_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_fire),
      .in_byte   (req_tdata),
      .is_last   (req_tlast),
      .out_limit (out_limit_ff),
      .result    (step_result)
   );

   always_comb begin
      out_limit_in = csr_wr_en ? csr_wr_data : out_limit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_limit_ff <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         out_limit_ff <= out_limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.out_valid;
   assign rsp_tdata  = {6'd0,
                        rsp_data_ff.produced_count,
                        rsp_data_ff.consumed_count,
                        rsp_data_ff.status,
                        rsp_data_ff.out_byte};

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while result stalled");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no result");

   a_no_byte_when_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'd0)
      else $error("byte present without out_valid");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:8] != 2'd3)
      else $error("undefined status code");

endmodule
